// ===== design/swmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t hi;
    word_t lo;
  } extremes_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== design/swmm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swmm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/swmm_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swmm_cmp
  import swmm_pkg::*;
(
  input  wire word_t     val,
  input  wire extremes_t cur,
  output extremes_t      nxt
);

  always_comb begin
    nxt.hi = (val > cur.hi) ? val : cur.hi;
    nxt.lo = (val < cur.lo) ? val : cur.lo;
  end

endmodule

`default_nettype wire

// ===== design/sliding_window_min_max_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Running maximum and minimum over the last WINDOW_DEPTH signed Q24.8 samples,
// one result beat per sample beat. The window starts as all zeros. A sample
// passes from acceptance through the update state to the done state when only
// the running extremes change, and through the scan state between them when
// the sample it pushes out was an extreme and the window is rescanned; the
// rescan reads the window memory one entry per cycle through its single read
// port and feeds one shared max/min comparator. No new sample is taken until
// the current one is finished. A fill count stands in for the zero reset of
// the memory, so there is no clearing pass after reset.
module sliding_window_min_max_unit
  import swmm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire word_t sample,
  output logic       out_valid,
  input  wire logic  out_stall,
  output word_t      window_max,
  output word_t      window_min
);

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW_DEPTH);

  state_t        state;
  logic [AW-1:0] ptr;
  logic [CW-1:0] fill;
  logic [CW-1:0] cnt;
  logic          scan_pend;
  logic [AW-1:0] scan_idx;
  word_t         new_sample;
  extremes_t     cur;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  word_t         ram_rdata;
  logic          rd_live;
  word_t         rd_val;
  word_t         cmp_val;
  extremes_t     cmp_cur;
  extremes_t     cmp_nxt;
  logic          in_beat;
  logic          out_load;

  swmm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (new_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swmm_cmp u_cmp (
    .val (cmp_val),
    .cur (cmp_cur),
    .nxt (cmp_nxt)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign ram_we   = (state == ST_UPD);
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    ram_raddr = ptr;
    if (state == ST_SCAN) begin
      ram_raddr = cnt[AW-1:0];
    end
  end

  // entries never written since reset read as zero
  always_comb begin
    rd_live = 1'b0;
    case (state)
      ST_UPD:  rd_live = CW'(ptr) < fill;
      ST_SCAN: rd_live = CW'(scan_idx) < fill;
      default: rd_live = 1'b0;
    endcase
    rd_val = rd_live ? ram_rdata : '0;
  end

  always_comb begin
    cmp_val = new_sample;
    cmp_cur = cur;
    if (state == ST_SCAN) begin
      cmp_val = rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      fill      <= '0;
      cnt       <= '0;
      scan_pend <= 1'b0;
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      scan_pend <= (state == ST_SCAN) && (cnt < FULL_CNT);
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          ptr <= (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
          if (fill != FULL_CNT) begin
            fill <= fill + 1'b1;
          end
          if (rd_val == cmp_nxt.hi || rd_val == cmp_nxt.lo) begin
            cur.hi <= new_sample;
            cur.lo <= new_sample;
            cnt    <= '0;
            state  <= ST_SCAN;
          end else begin
            cur   <= cmp_nxt;
            state <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (scan_pend) begin
            cur <= cmp_nxt;
          end
          if (cnt == FULL_CNT) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      new_sample <= sample;
    end
    if (state == ST_SCAN) begin
      scan_idx <= cnt[AW-1:0];
    end
    if (out_load) begin
      window_max <= cur.hi;
      window_min <= cur.lo;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill count beyond window depth");

  a_max_ge_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_max >= window_min)
    else $error("reported maximum below minimum");

  a_upd_next: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |=> state == ST_SCAN || state == ST_DONE)
    else $error("update step not followed by scan or done");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_pend |-> state == ST_SCAN)
    else $error("scan read pending outside scan");
`endif

endmodule

`default_nettype wire

// ===== sim/sliding_window_min_max_unit_tb.sv =====
`timescale 1ns / 1ps

import swmm_pkg::*;

class swmm_scoreboard #(int unsigned DEPTH = 64);
  word_t       ring[DEPTH];
  int unsigned head;
  word_t       run_max;
  word_t       run_min;
  extremes_t   pending[$];
  int unsigned failures;

  function new();
    foreach (ring[k]) ring[k] = '0;
    head     = 0;
    run_max  = '0;
    run_min  = '0;
    failures = 0;
  endfunction

  function void note_sample(word_t s);
    word_t     leaving;
    extremes_t entry;
    leaving    = ring[head];
    ring[head] = s;
    head       = (head + 1) % DEPTH;
    if (s > run_max) run_max = s;
    if (s < run_min) run_min = s;
    if (leaving == run_max || leaving == run_min) begin
      run_max = ring[head];
      run_min = ring[head];
      foreach (ring[k]) begin
        if (ring[k] > run_max) run_max = ring[k];
        if (ring[k] < run_min) run_min = ring[k];
      end
    end
    entry.hi = run_max;
    entry.lo = run_min;
    pending.insert(pending.size(), entry);
  endfunction

  function void check_result(word_t got_max, word_t got_min);
    extremes_t want;
    if (pending.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result beat: max %0d min %0d", got_max, got_min);
    end else begin
      want = pending[0];
      pending.delete(0);
      if (want.hi !== got_max || want.lo !== got_min) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected max %0d min %0d, got max %0d min %0d",
                   want.hi, want.lo, got_max, got_min);
      end
    end
  endfunction
endclass

module sliding_window_min_max_unit_tb;

  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef enum int unsigned {
    MIX_FULL,
    MIX_NARROW,
    MIX_RISING,
    MIX_FALLING,
    MIX_FLAT,
    MIX_EDGE
  } mix_t;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  word_t sample    = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t window_max;
  word_t window_min;

  bit          quiet       = 1'b0;
  bit          stall_next  = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;

  swmm_scoreboard #(WINDOW_DEPTH) sb;

  sliding_window_min_max_unit #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .window_max(window_max),
    .window_min(window_min)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) begin : stall_gen
    int unsigned r;
    if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        stall_next = 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (r < 92) begin
        stall_next = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_next = 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
    stall_left--;
    out_stall <= stall_next && !quiet;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(window_max, window_min);
  end

  task automatic send_sample(input word_t v);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (in_stall);
    sb.note_sample(v);
    @(negedge clk);
  endtask

  initial begin
    word_t       directed[$];
    word_t       v;
    word_t       base;
    word_t       step;
    mix_t        mix;
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;

    sb = new();
    directed = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, -32'sd1, 32'sd1,
                 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 32'sd256, -32'sd256, 32'sh00000000, 32'sh00000000, 32'sh55555555,
                 32'shAAAAAAAA, 32'sd256, -32'sd1, 32'sh7FFFFF00};

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[d]) send_sample(directed[d]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix     = mix_t'($urandom_range(0, 5));
      quiet   = ($urandom_range(0, 4) == 0);
      run_len = $urandom_range(8, 80);
      base    = $urandom;
      step    = $urandom_range(0, 3);
      for (k = 0; k < run_len; k++) begin
        case (mix)
          MIX_FULL:    v = $urandom;
          MIX_NARROW:  v = word_t'(int'($urandom_range(0, 8)) - 4);
          MIX_RISING:  v = base + step * word_t'(k);
          MIX_FALLING: v = base - step * word_t'(k);
          MIX_FLAT:    v = base;
          default: begin
            case ($urandom_range(0, 3))
              0:       v = 32'sh7FFFFFFF;
              1:       v = 32'sh80000000;
              2:       v = '0;
              default: v = '1;
            endcase
          end
        endcase
        send_sample(v);
      end
      sent += run_len;
    end

    in_valid <= 1'b0;
    quiet = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (WINDOW_DEPTH + 8) @(posedge clk);

    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
